FILE: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// Positional sequence store package
// Shared constants, codes and word types of the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_W     = 64;
  localparam int POS_W       = 11;
  localparam int COUNT_W     = 11;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W       = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int TREE_LEVELS = (IDX_W + 1) / 2;
  localparam int TREE_LEAVES = 1 << (2 * TREE_LEVELS);
  localparam int STEP_W      = $clog2(TREE_LEVELS + 1);

  typedef enum logic [1:0] {
    ActInsert = 2'd0,
    ActRemove = 2'd1,
    ActGet    = 2'd2,
    ActClear  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    action_e              action;
    logic [POS_W-1:0]     position;
    logic [VALUE_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   read_value;
    logic [COUNT_W-1:0]   element_count;
    status_e              status;
  } result_t;

  typedef struct packed {
    logic                 shift_ins;
    logic                 shift_rem;
    logic [CMP_W-1:0]     pos;
    logic [VALUE_W-1:0]   value;
  } cell_ctrl_t;

endpackage

FILE: rtl/pss_cell.sv
// ----------------------------------------------------------------------------
// Positional sequence store cell
// Holds one entry; at or above the position, takes the value or left neighbour's word
// on insert and right neighbour's word on remove; offers its word when its index is selected.
// ----------------------------------------------------------------------------
module pss_cell (
  input  logic                        clk_i,
  input  pss_pkg::cell_ctrl_t         ctrl_i,
  input  logic [pss_pkg::IDX_W-1:0]   idx_i,
  input  logic [pss_pkg::VALUE_W-1:0] left_i,
  input  logic [pss_pkg::VALUE_W-1:0] right_i,
  output logic [pss_pkg::VALUE_W-1:0] data_o,
  output logic [pss_pkg::VALUE_W-1:0] read_o
);
  import pss_pkg::*;

  logic [VALUE_W-1:0] data_q, data_d;
  logic [CMP_W-1:0]   idx_ext;

  assign idx_ext = CMP_W'(idx_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_ins) begin
      if (idx_ext == ctrl_i.pos) begin
        data_d = ctrl_i.value;
      end else if (idx_ext > ctrl_i.pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.shift_rem && (idx_ext >= ctrl_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign read_o = (idx_ext == ctrl_i.pos) ? data_q : '0;

endmodule

FILE: rtl/pss_read_tree.sv
// ----------------------------------------------------------------------------
// Positional sequence store read tree
// Registered four-way OR tree that gathers the one selected cell word.
// ----------------------------------------------------------------------------
module pss_read_tree (
  input  logic                        clk_i,
  input  logic [pss_pkg::VALUE_W-1:0] leaf_i [pss_pkg::CAPACITY],
  output logic [pss_pkg::VALUE_W-1:0] root_o
);
  import pss_pkg::*;

  logic [VALUE_W-1:0] leaf_pad [TREE_LEAVES];

  for (genvar k = 0; k < TREE_LEAVES; k++) begin : g_pad
    if (k < CAPACITY) begin : g_used
      assign leaf_pad[k] = leaf_i[k];
    end else begin : g_zero
      assign leaf_pad[k] = '0;
    end
  end

  for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_lvl
    logic [VALUE_W-1:0] node_q [TREE_LEAVES >> (2 * (l + 1))];
    for (genvar j = 0; j < (TREE_LEAVES >> (2 * (l + 1))); j++) begin : g_node
      if (l == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          node_q[j] <= leaf_pad[4*j] | leaf_pad[4*j+1]
                     | leaf_pad[4*j+2] | leaf_pad[4*j+3];
        end
      end else begin : g_upper
        always_ff @(posedge clk_i) begin
          node_q[j] <= g_lvl[l-1].node_q[4*j] | g_lvl[l-1].node_q[4*j+1]
                     | g_lvl[l-1].node_q[4*j+2] | g_lvl[l-1].node_q[4*j+3];
        end
      end
    end
  end

  assign root_o = g_lvl[TREE_LEVELS-1].node_q[0];

endmodule

FILE: rtl/positional_sequence_store_top.sv
// ----------------------------------------------------------------------------
// Positional sequence store
// Ordered sequence of 64-bit entries kept in a row of cells, by position.
// ----------------------------------------------------------------------------
// A word is accepted on a rising edge with start high and busy low. It
// carries an action (insert, remove, get or clear), a position and a value.
// Each word yields exactly one result word on result_o, marked by done_o for
// a single cycle; the receiver cannot stall it and must take it then.
// The result holds the value read or removed, the count after the word and a
// status: ok, position out of range, or store full on insert.
// Busy stays high from the accepting edge until the word finishes, and done_o
// is high in the first cycle with busy low, in which the next word may be
// accepted; no new word is taken while one is in progress. How long busy
// stays high is set by the depth of the registered four-way read tree that
// gathers the selected cell.
// Insert and remove shift all cells from the position onward together, as the word finishes.
// Reset clears the count and the handshake; cell contents are left as they
// are and are never read before being written.
// ----------------------------------------------------------------------------
module positional_sequence_store_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pss_pkg::item_t   item_i,
  output logic             done_o,
  output pss_pkg::result_t result_o
);
  import pss_pkg::*;

  logic                 busy_q;
  logic [STEP_W-1:0]    step_q;
  logic                 done_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  action_e              act_q;
  logic [POS_W-1:0]     pos_q;
  logic [VALUE_W-1:0]   value_q;
  status_e              status_q, status_d;
  result_t              result_q;
  logic                 accept, finish, ok;
  cell_ctrl_t           ctrl;
  logic [VALUE_W-1:0]   cell_data [CAPACITY];
  logic [VALUE_W-1:0]   cell_read [CAPACITY];
  logic [VALUE_W-1:0]   tree_root;

  assign accept = start && !busy_q;
  assign finish = busy_q && (step_q == STEP_W'(TREE_LEVELS));
  assign ok     = (status_q == StOk);

  always_comb begin
    status_d = StOk;
    case (item_i.action)
      ActInsert: begin
        if (item_i.position > count_q) begin
          status_d = StRange;
        end else if (32'(count_q) >= 32'(CAPACITY)) begin
          status_d = StFull;
        end
      end
      ActRemove, ActGet: begin
        if (item_i.position >= count_q) begin
          status_d = StRange;
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  always_comb begin
    ctrl.shift_ins = finish && ok && (act_q == ActInsert);
    ctrl.shift_rem = finish && ok && (act_q == ActRemove);
    ctrl.pos       = CMP_W'(pos_q);
    ctrl.value     = value_q;
  end

  always_comb begin
    count_d = count_q;
    case (act_q)
      ActInsert: if (ok) count_d = count_q + COUNT_W'(1);
      ActRemove: if (ok) count_d = count_q - COUNT_W'(1);
      ActClear:  count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= finish;
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (finish) begin
        busy_q  <= 1'b0;
        count_q <= count_d;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= item_i.action;
      pos_q    <= item_i.position;
      value_q  <= item_i.value;
      status_q <= status_d;
    end
    if (finish) begin
      result_q.read_value    <= (ok && ((act_q == ActRemove) || (act_q == ActGet)))
                                ? tree_root : '0;
      result_q.element_count <= count_d;
      result_q.status        <= status_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left, right;
    if (i == 0) begin : g_lfirst
      assign left = '0;
    end else begin : g_lmid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_rlast
      assign right = '0;
    end else begin : g_rmid
      assign right = cell_data[i+1];
    end
    pss_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(i)),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .read_o  (cell_read[i])
    );
  end

  pss_read_tree u_read_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_read),
    .root_o (tree_root)
  );

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
